@@ hdl/sfd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfd_pkg
// Types and constants shared by the status frame deframer and its checker.
// ----------------------------------------------------------------------------
package sfd_pkg;

    localparam logic [7:0] SYNC_A    = 8'hFC;
    localparam logic [7:0] SYNC_B    = 8'h2C;
    localparam logic [7:0] SYNC_C    = 8'h55;
    localparam logic [7:0] MIN_LEN   = 8'd2;
    localparam logic [8:0] LEN_EXTRA = 9'd5;

    localparam logic [15:0] STATUS_CMD_RESET   = 16'h0014;
    localparam logic [7:0]  MIN_PAYLOAD_RESET  = 8'd60;

    // Register indexes on the configuration channel.
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_STATUS_CMD  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_PAYLOAD = 2'd1;

    // Frame positions that carry captured fields.
    localparam logic [8:0] POS_CMD_LO   = 9'd4;
    localparam logic [8:0] POS_CMD_HI   = 9'd5;
    localparam logic [8:0] POS_SERVO    = 9'd12;
    localparam logic [8:0] POS_YAW_LO   = 9'd45;
    localparam logic [8:0] POS_YAW_HI   = 9'd46;
    localparam logic [8:0] POS_PITCH_LO = 9'd47;
    localparam logic [8:0] POS_PITCH_HI = 9'd48;
    localparam logic [8:0] POS_ROLL_LO  = 9'd49;
    localparam logic [8:0] POS_ROLL_HI  = 9'd50;
    localparam logic [8:0] POS_ACK      = 9'd52;
    localparam logic [8:0] POS_GUIDE    = 9'd53;

    localparam int unsigned OUT_DATA_W = 96;

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_SYNC_B,
        PH_SYNC_C,
        PH_LEN,
        PH_BODY
    } phase_t;

    typedef enum logic [1:0] {
        ST_PARSED    = 2'd0,
        ST_OTHER_CMD = 2'd1,
        ST_CSUM_ERR  = 2'd2,
        ST_TOO_SHORT = 2'd3
    } frame_status_t;

endpackage

@@ hdl/status_frame_deframer_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// status_frame_deframer_unit
// Byte-serial parser for FC 2C 55 status frames with XOR checksum.
// ----------------------------------------------------------------------------
//  Channel   Direction  Width  Contents
//  s_axis    in         8      rx_byte
//  m_axis    out        96     frame status, command word, angles, status bytes
//  cfg       in         2+16   register index, write data
//
// One byte is taken per cycle; the frame state updates at the transfer and a
// frame's result lands in the output register at the edge that takes its last
// byte. The single output register sets the rate: the input stalls only while
// a result waits and m_tready is low.
// Reset (aresetn, synchronous) returns to hunting and drops any pending result.
module status_frame_deframer_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    // [1:0] frame_status, [17:2] command_word, [33:18] yaw_centideg,
    // [49:34] pitch_centideg, [65:50] roll_centideg, [73:66] servo_flags,
    // [81:74] command_ack, [89:82] guide_flags, [95:90] zero
    output logic [sfd_pkg::OUT_DATA_W-1:0] m_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [sfd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0] cfg_data
);

    sfd_pkg::phase_t phase_reg, phase_next;
    logic [15:0] status_cmd_reg;
    logic [7:0]  min_payload_reg;
    logic [7:0]  len_reg, len_next;
    logic [8:0]  pos_reg, pos_next;
    logic [7:0]  xor_reg, xor_next;
    logic [15:0] cmd_reg, cmd_next;
    logic [7:0]  low_reg, low_next;
    logic [15:0] yaw_reg, yaw_next, pitch_reg, pitch_next, roll_reg, roll_next;
    logic [7:0]  servo_reg, servo_next, ack_reg, ack_next, guide_reg, guide_next;
    logic        out_valid_reg, out_valid_next;
    logic [sfd_pkg::OUT_DATA_W-1:0] out_data_reg, out_data_next;

    logic        accept;
    logic [7:0]  rx_byte;
    logic [8:0]  last_pos;
    logic        at_last;
    logic        emit;
    sfd_pkg::frame_status_t status;
    logic [15:0] word;
    logic        parsed;

    assign rx_byte   = s_tdata;
    assign s_tready  = !out_valid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    assign last_pos = {1'b0, len_reg} + sfd_pkg::LEN_EXTRA - 9'd1;
    assign at_last  = (pos_reg == last_pos);
    assign emit     = accept && (phase_reg == sfd_pkg::PH_BODY) && at_last;
    assign word     = {rx_byte, low_reg};

    // Next phase.
    always_comb begin
        phase_next = phase_reg;
        if (accept) begin
            case (phase_reg)
                sfd_pkg::PH_HUNT: begin
                    phase_next = (rx_byte == sfd_pkg::SYNC_A) ? sfd_pkg::PH_SYNC_B
                                                              : sfd_pkg::PH_HUNT;
                end
                sfd_pkg::PH_SYNC_B: begin
                    if (rx_byte == sfd_pkg::SYNC_B) phase_next = sfd_pkg::PH_SYNC_C;
                    else if (rx_byte == sfd_pkg::SYNC_A) phase_next = sfd_pkg::PH_SYNC_B;
                    else phase_next = sfd_pkg::PH_HUNT;
                end
                sfd_pkg::PH_SYNC_C: begin
                    if (rx_byte == sfd_pkg::SYNC_C) phase_next = sfd_pkg::PH_LEN;
                    else if (rx_byte == sfd_pkg::SYNC_A) phase_next = sfd_pkg::PH_SYNC_B;
                    else phase_next = sfd_pkg::PH_HUNT;
                end
                sfd_pkg::PH_LEN: begin
                    phase_next = (rx_byte < sfd_pkg::MIN_LEN) ? sfd_pkg::PH_HUNT
                                                              : sfd_pkg::PH_BODY;
                end
                sfd_pkg::PH_BODY: begin
                    phase_next = at_last ? sfd_pkg::PH_HUNT : sfd_pkg::PH_BODY;
                end
                default: begin
                    phase_next = sfd_pkg::PH_HUNT;
                end
            endcase
        end
    end

    // Frame datapath: length, position, checksum and captured fields.
    always_comb begin
        len_next   = len_reg;
        pos_next   = pos_reg;
        xor_next   = xor_reg;
        cmd_next   = cmd_reg;
        low_next   = low_reg;
        yaw_next   = yaw_reg;
        pitch_next = pitch_reg;
        roll_next  = roll_reg;
        servo_next = servo_reg;
        ack_next   = ack_reg;
        guide_next = guide_reg;
        if (accept) begin
            case (phase_reg)
                sfd_pkg::PH_LEN: begin
                    if (rx_byte >= sfd_pkg::MIN_LEN) begin
                        // Fields that a short frame never reaches stay zero.
                        len_next   = rx_byte;
                        xor_next   = rx_byte;
                        pos_next   = sfd_pkg::POS_CMD_LO;
                        yaw_next   = '0;
                        pitch_next = '0;
                        roll_next  = '0;
                        servo_next = '0;
                        ack_next   = '0;
                        guide_next = '0;
                    end
                end
                sfd_pkg::PH_BODY: begin
                    if (!at_last) begin
                        xor_next = xor_reg ^ rx_byte;
                        pos_next = pos_reg + 9'd1;
                        case (pos_reg)
                            sfd_pkg::POS_CMD_LO,
                            sfd_pkg::POS_YAW_LO,
                            sfd_pkg::POS_PITCH_LO,
                            sfd_pkg::POS_ROLL_LO:   low_next   = rx_byte;
                            sfd_pkg::POS_CMD_HI:    cmd_next   = word;
                            sfd_pkg::POS_YAW_HI:    yaw_next   = word;
                            sfd_pkg::POS_PITCH_HI:  pitch_next = word;
                            sfd_pkg::POS_ROLL_HI:   roll_next  = word;
                            sfd_pkg::POS_SERVO:     servo_next = rx_byte;
                            sfd_pkg::POS_ACK:       ack_next   = rx_byte;
                            sfd_pkg::POS_GUIDE:     guide_next = rx_byte;
                            default: ;
                        endcase
                    end
                end
                default: ;
            endcase
        end
    end

    // Status of the frame whose checksum byte is on the input.
    always_comb begin
        if (xor_reg != rx_byte) status = sfd_pkg::ST_CSUM_ERR;
        else if (cmd_reg != status_cmd_reg) status = sfd_pkg::ST_OTHER_CMD;
        else if ((len_reg - sfd_pkg::MIN_LEN) < min_payload_reg)
            status = sfd_pkg::ST_TOO_SHORT;
        else status = sfd_pkg::ST_PARSED;
    end

    assign parsed = (status == sfd_pkg::ST_PARSED);

    always_comb begin
        out_valid_next = accept ? emit : (out_valid_reg && !m_tready);
        out_data_next  = out_data_reg;
        if (emit) begin
            out_data_next = {6'd0,
                             parsed ? guide_reg : 8'd0,
                             parsed ? ack_reg   : 8'd0,
                             parsed ? servo_reg : 8'd0,
                             parsed ? roll_reg  : 16'd0,
                             parsed ? pitch_reg : 16'd0,
                             parsed ? yaw_reg   : 16'd0,
                             cmd_reg,
                             status};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= sfd_pkg::PH_HUNT;
            status_cmd_reg  <= sfd_pkg::STATUS_CMD_RESET;
            min_payload_reg <= sfd_pkg::MIN_PAYLOAD_RESET;
            len_reg         <= '0;
            pos_reg         <= '0;
            xor_reg         <= '0;
            cmd_reg         <= '0;
            low_reg         <= '0;
            yaw_reg         <= '0;
            pitch_reg       <= '0;
            roll_reg        <= '0;
            servo_reg       <= '0;
            ack_reg         <= '0;
            guide_reg       <= '0;
            out_valid_reg   <= 1'b0;
        end else begin
            phase_reg     <= phase_next;
            len_reg       <= len_next;
            pos_reg       <= pos_next;
            xor_reg       <= xor_next;
            cmd_reg       <= cmd_next;
            low_reg       <= low_next;
            yaw_reg       <= yaw_next;
            pitch_reg     <= pitch_next;
            roll_reg      <= roll_next;
            servo_reg     <= servo_next;
            ack_reg       <= ack_next;
            guide_reg     <= guide_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    sfd_pkg::REG_STATUS_CMD:  status_cmd_reg  <= cfg_data;
                    sfd_pkg::REG_MIN_PAYLOAD: min_payload_reg <= cfg_data[7:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg <= out_data_next;
    end

endmodule

@@ hdl/sfd_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfd_checker
// Port-level checks on the status frame deframer, bound to the top level.
// ----------------------------------------------------------------------------
module sfd_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [sfd_pkg::OUT_DATA_W-1:0] m_tdata
);

    // A result that is not taken holds still.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // The input stalls exactly while a result waits and m_tready is low.
    a_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready does not follow the output register");

    // Captured payload fields are cleared unless the frame was parsed.
    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[1:0] != sfd_pkg::ST_PARSED) |-> m_tdata[89:18] == '0)
        else $error("payload fields set on a rejected frame");

    // Padding above the last field stays zero.
    a_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[95:90] == '0)
        else $error("padding bits set");

endmodule

bind status_frame_deframer_unit sfd_checker u_sfd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
